// ----- hdl/smeng_pkg.sv -----
// ----------------------------------------------------------------------------
// smeng_pkg
// Shared codes, state encoding and control bundle of the scratchpad engine.
// ----------------------------------------------------------------------------
package smeng_pkg;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_MM    = 3'd2;
    localparam logic [2:0] CMD_BF    = 3'd3;
    localparam logic [2:0] CMD_FENCE = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam int FIELD_W = 10;

    typedef enum logic [15:0] {
        S_CLEAR     = 16'h0001,
        S_IDLE      = 16'h0002,
        S_DECODE    = 16'h0004,
        S_ELEM_RD   = 16'h0008,
        S_ELEM_DO   = 16'h0010,
        S_ROW_RDA   = 16'h0020,
        S_ROW_RDB   = 16'h0040,
        S_ROW_LDB   = 16'h0080,
        S_ROW_INIT  = 16'h0100,
        S_COL_START = 16'h0200,
        S_K_RD      = 16'h0400,
        S_K_MUL     = 16'h0800,
        S_K_ACC     = 16'h1000,
        S_COL_WR    = 16'h2000,
        S_ROW_WR    = 16'h4000,
        S_FINISH    = 16'h8000
    } state_t;

    typedef enum logic [1:0] {
        WSRC_ZERO = 2'd0,
        WSRC_DST  = 2'd1,
        WSRC_ELEM = 2'd2
    } wsrc_t;

    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        wsrc_t wr_src;
        logic  ld_arow;
        logic  ld_brow;
        logic  dst_init;
        logic  acc_clr;
        logic  mul_en;
        logic  acc_add;
        logic  col_wr;
        logic  elem_cap;
        logic  out_load;
        logic  out_rd;
        logic  a_is_dst;
        logic  b_is_dst;
        logic  bf;
    } ctl_t;

endpackage

// ----- hdl/smeng_ctrl.sv -----
// ----------------------------------------------------------------------------
// smeng_ctrl
// Command sequencer: decode, range checks, row/column/term loops, clear sweep.
// ----------------------------------------------------------------------------
module smeng_ctrl #(
    parameter int DIM     = 16,
    parameter int SP_ROWS = 1024,
    parameter int RW      = 10,
    parameter int CW      = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  logic [2:0]           cmd,
    input  logic [9:0]           row_a,
    input  logic [9:0]           row_b,
    input  logic [9:0]           row_dst,
    input  logic [9:0]           count,
    input  logic [3:0]           col,
    input  logic [7:0]           write_value,
    input  logic                 out_free,
    output smeng_pkg::ctl_t      ctl,
    output logic [RW-1:0]        rd_addr,
    output logic [RW-1:0]        wr_addr,
    output logic [CW-1:0]        k_idx,
    output logic [CW-1:0]        c_idx,
    output logic [7:0]           elem_val,
    output logic [1:0]           out_status
);
    import smeng_pkg::*;

    localparam int SW = ((RW > FIELD_W) ? RW : FIELD_W) + 2;
    localparam logic [SW-1:0] SPR  = SW'(SP_ROWS);
    localparam logic [SW-1:0] DIMS = SW'(DIM);
    localparam logic [CW-1:0] LAST = CW'(DIM - 1);

    state_t state_reg, state_next;
    logic [2:0]    cmd_reg;
    logic [9:0]    ra_reg, rb_reg, rd_reg, n_reg, i_reg, i_next;
    logic [3:0]    col_reg;
    logic [7:0]    wv_reg;
    logic [1:0]    st_reg, st_next;
    logic [CW-1:0] k_reg, k_next, c_reg, c_next;
    logic [RW-1:0] clr_reg, clr_next;
    logic          bf;
    logic [SW-1:0] a_row, b_row_mm, b_row_bf, d_row, bend;
    logic          bad_range, elem_bad;

    assign bf       = (cmd_reg == CMD_BF);
    assign a_row    = SW'(ra_reg) + SW'(i_reg);
    assign d_row    = SW'(rd_reg) + SW'(i_reg);
    assign b_row_mm = SW'(rb_reg) + SW'(k_reg);
    assign b_row_bf = SW'(rb_reg) + SW'(i_reg);
    assign bend     = SW'(rb_reg) + (bf ? SW'(n_reg) : DIMS);
    assign bad_range = (SW'(ra_reg) + SW'(n_reg) > SPR) || (SW'(rd_reg) + SW'(n_reg) > SPR)
                     || (bend > SPR);
    assign elem_bad  = (SW'(ra_reg) >= SPR) || (int'(col_reg) >= DIM);

    assign cmd_ready  = (state_reg == S_IDLE);
    assign elem_val   = wv_reg;
    assign out_status = st_reg;
    assign k_idx      = k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            c_reg     <= '0;
            st_reg    <= ST_DONE;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_valid && cmd_ready) begin
            cmd_reg <= cmd;
            ra_reg  <= row_a;
            rb_reg  <= row_b;
            rd_reg  <= row_dst;
            n_reg   <= count;
            col_reg <= col;
            wv_reg  <= write_value;
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        st_next    = st_reg;
        ctl        = '0;
        ctl.bf     = bf;
        ctl.a_is_dst = (ra_reg == rd_reg);
        ctl.b_is_dst = bf ? (rb_reg == rd_reg) : (b_row_mm == d_row);
        rd_addr    = a_row[RW-1:0];
        wr_addr    = d_row[RW-1:0];
        c_idx      = c_reg;
        case (state_reg)
            S_CLEAR: begin
                ctl.wr_en  = 1'b1;
                ctl.wr_src = WSRC_ZERO;
                wr_addr    = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == RW'(SP_ROWS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                st_next    = ST_DONE;
                i_next     = '0;
                state_next = S_FINISH;
                case (cmd_reg)
                    CMD_WRITE, CMD_READ: begin
                        if (elem_bad) begin
                            st_next = ST_RANGE;
                        end else begin
                            state_next = S_ELEM_RD;
                        end
                    end
                    CMD_MM, CMD_BF: begin
                        if (n_reg != '0) begin
                            if (bad_range) begin
                                st_next = ST_RANGE;
                            end else begin
                                state_next = S_ROW_RDA;
                            end
                        end
                    end
                    CMD_FENCE: begin
                        st_next = ST_DONE;
                    end
                    default: begin
                        st_next = ST_ILLEGAL;
                    end
                endcase
            end
            S_ELEM_RD: begin
                ctl.rd_en  = 1'b1;
                rd_addr    = RW'(ra_reg);
                state_next = S_ELEM_DO;
            end
            S_ELEM_DO: begin
                c_idx   = CW'(col_reg);
                wr_addr = RW'(ra_reg);
                if (cmd_reg == CMD_WRITE) begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_src = WSRC_ELEM;
                end else begin
                    ctl.elem_cap = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_ROW_RDA: begin
                ctl.rd_en  = 1'b1;
                state_next = S_ROW_RDB;
            end
            S_ROW_RDB: begin
                ctl.ld_arow = 1'b1;
                if (bf) begin
                    ctl.rd_en  = 1'b1;
                    rd_addr    = b_row_bf[RW-1:0];
                    state_next = S_ROW_LDB;
                end else begin
                    state_next = S_ROW_INIT;
                end
            end
            S_ROW_LDB: begin
                ctl.ld_brow = 1'b1;
                state_next  = S_ROW_INIT;
            end
            S_ROW_INIT: begin
                ctl.dst_init = 1'b1;
                c_next       = bf ? CW'(1) : '0;
                state_next   = S_COL_START;
            end
            S_COL_START: begin
                ctl.acc_clr = 1'b1;
                k_next      = bf ? CW'(1) : '0;
                state_next  = bf ? S_K_MUL : S_K_RD;
            end
            S_K_RD: begin
                ctl.rd_en  = 1'b1;
                rd_addr    = b_row_mm[RW-1:0];
                state_next = S_K_MUL;
            end
            S_K_MUL: begin
                ctl.mul_en = 1'b1;
                state_next = S_K_ACC;
            end
            S_K_ACC: begin
                ctl.acc_add = 1'b1;
                k_next      = k_reg + 1'b1;
                if (k_reg == LAST) begin
                    state_next = S_COL_WR;
                end else begin
                    state_next = bf ? S_K_MUL : S_K_RD;
                end
            end
            S_COL_WR: begin
                ctl.col_wr = 1'b1;
                c_next     = c_reg + 1'b1;
                state_next = (c_reg == LAST) ? S_ROW_WR : S_COL_START;
            end
            S_ROW_WR: begin
                ctl.wr_en  = 1'b1;
                ctl.wr_src = WSRC_DST;
                i_next     = i_reg + 1'b1;
                state_next = (i_reg == n_reg - 1'b1) ? S_FINISH : S_ROW_RDA;
            end
            S_FINISH: begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    ctl.out_rd   = (cmd_reg == CMD_READ) && (st_reg == ST_DONE);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/smeng_dpath.sv -----
// ----------------------------------------------------------------------------
// smeng_dpath
// Scratchpad memory, row buffers, multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module smeng_dpath #(
    parameter int DIM        = 16,
    parameter int SP_ROWS    = 1024,
    parameter int ELEM_WIDTH = 8,
    parameter int RW         = 10,
    parameter int CW         = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  smeng_pkg::ctl_t ctl,
    input  logic [RW-1:0]   rd_addr,
    input  logic [RW-1:0]   wr_addr,
    input  logic [CW-1:0]   k_idx,
    input  logic [CW-1:0]   c_idx,
    input  logic [7:0]      elem_val,
    input  logic [1:0]      out_status,
    output logic            out_free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata
);
    import smeng_pkg::*;

    localparam int EW = ELEM_WIDTH;

    logic [DIM-1:0][EW-1:0] mem [SP_ROWS];
    logic [DIM-1:0][EW-1:0] rdata_reg, arow_reg, brow_reg, dst_reg, wdata;
    logic [DIM-1:0][EW-1:0] dst_init_val;
    logic [EW-1:0]   acc_reg, prod_reg, a_op, b_op, wv_elem;
    logic [2*EW-1:0] full;
    logic [31:0]     wv32, rv32;
    logic [7:0]      rv_reg;
    logic            out_valid_reg;
    logic [9:0]      out_data_reg;

    assign wv32    = 32'($signed(elem_val));
    assign wv_elem = wv32[EW-1:0];
    assign rv32    = 32'($signed(rdata_reg[c_idx]));

    always_comb begin
        case (ctl.wr_src)
            WSRC_ZERO: wdata = '0;
            WSRC_DST:  wdata = dst_reg;
            WSRC_ELEM: begin
                wdata        = rdata_reg;
                wdata[c_idx] = wv_elem;
            end
            default:   wdata = '0;
        endcase
    end

    // cleared destination row, block-float puts the exponent sum in column 0
    always_comb begin
        dst_init_val = '0;
        if (ctl.bf) begin
            dst_init_val[0] = arow_reg[0] + brow_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wdata;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign a_op = ctl.a_is_dst ? dst_reg[k_idx] : arow_reg[k_idx];
    assign b_op = ctl.bf ? (ctl.b_is_dst ? dst_reg[k_idx] : brow_reg[k_idx])
                         : (ctl.b_is_dst ? dst_reg[c_idx] : rdata_reg[c_idx]);
    assign full = (2*EW)'(a_op) * (2*EW)'(b_op);

    always_ff @(posedge aclk) begin
        if (ctl.ld_arow) begin
            arow_reg <= rdata_reg;
        end
        if (ctl.ld_brow) begin
            brow_reg <= rdata_reg;
        end
        if (ctl.dst_init) begin
            dst_reg <= dst_init_val;
        end else if (ctl.col_wr) begin
            dst_reg[c_idx] <= acc_reg;
        end
        if (ctl.mul_en) begin
            prod_reg <= full[EW-1:0];
        end
        if (ctl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctl.acc_add) begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (ctl.elem_cap) begin
            rv_reg <= rv32[7:0];
        end
        if (ctl.out_load) begin
            out_data_reg <= {out_status, ctl.out_rd ? rv_reg : 8'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule

// ----- hdl/scratchpad_matrix_engine.sv -----
// ----------------------------------------------------------------------------
// scratchpad_matrix_engine
// Command engine over a row-organized scratchpad with matrix multiply.
// ----------------------------------------------------------------------------
// usage
//   s_ channel carries one command per transfer, m_ channel returns one result
//   per command: read value and status.
//   element write/read: decode, row read, then element write or capture.
//   matmul: one shared multiplier and one scratchpad row read per product
//   term set the run time.
//   block-float: the two operand rows are buffered so only the multiplier
//   loop remains.
//   fence, illegal and out-of-range commands: decode, then the result.
//   one command is worked on at a time; the next is taken once the result
//   sits in the output register, even while that register is not yet taken.
//   after reset a clearing sweep writes zero to all SP_ROWS rows, one row per
//   cycle; s_tready stays low during the sweep.
//   a stalled m_ side holds the result; the engine waits before its next
//   result and keeps the output stable.
// ----------------------------------------------------------------------------
module scratchpad_matrix_engine #(
    parameter int DIM        = 16,
    parameter int SP_ROWS    = 1024,
    parameter int ELEM_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd, row_a, row_b, row_dst, count, col, write_value, zero pad
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value, status, zero pad
    output logic [15:0] m_tdata
);
    import smeng_pkg::*;

    localparam int RW = (SP_ROWS > 1) ? $clog2(SP_ROWS) : 1;
    localparam int CW = $clog2(DIM);

    ctl_t          ctl;
    logic [RW-1:0] rd_addr, wr_addr;
    logic [CW-1:0] k_idx, c_idx;
    logic [7:0]    elem_val;
    logic [1:0]    out_status;
    logic          out_free;

    smeng_ctrl #(
        .DIM(DIM), .SP_ROWS(SP_ROWS), .RW(RW), .CW(CW)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd_valid(s_tvalid),
        .cmd_ready(s_tready),
        .cmd(s_tdata[2:0]),
        .row_a(s_tdata[12:3]),
        .row_b(s_tdata[22:13]),
        .row_dst(s_tdata[32:23]),
        .count(s_tdata[42:33]),
        .col(s_tdata[46:43]),
        .write_value(s_tdata[54:47]),
        .out_free(out_free),
        .ctl(ctl),
        .rd_addr(rd_addr),
        .wr_addr(wr_addr),
        .k_idx(k_idx),
        .c_idx(c_idx),
        .elem_val(elem_val),
        .out_status(out_status)
    );

    smeng_dpath #(
        .DIM(DIM), .SP_ROWS(SP_ROWS), .ELEM_WIDTH(ELEM_WIDTH), .RW(RW), .CW(CW)
    ) u_dpath (
        .aclk(aclk),
        .aresetn(aresetn),
        .ctl(ctl),
        .rd_addr(rd_addr),
        .wr_addr(wr_addr),
        .k_idx(k_idx),
        .c_idx(c_idx),
        .elem_val(elem_val),
        .out_status(out_status),
        .out_free(out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

endmodule

// ----- hdl/smeng_checker.sv -----
// ----------------------------------------------------------------------------
// smeng_checker
// Port-level checks of the scratchpad engine, bound to the top level.
// ----------------------------------------------------------------------------
module smeng_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:8] != 2'b11)
        else $error("undefined status code");

    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] != 2'b00 |-> m_tdata[7:0] == 8'd0)
        else $error("read value nonzero on error");

    a_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("command taken during clearing sweep");

    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken before first completed");

endmodule

bind scratchpad_matrix_engine smeng_checker u_smeng_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

// ----- sim/tb_scratchpad_matrix_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scratchpad_matrix_engine
// Drives commands into the scratchpad engine and checks every returned read
// value and status against a cycle-free model of the scratchpad kept in a
// small scoreboard class. Directed corner commands come first, then random
// traffic concentrated on a small row window so that reads and multiplies
// see written data, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_scratchpad_matrix_engine;
    import smeng_pkg::*;

    localparam int NDIM      = 16;
    localparam int NROWS     = 1024;
    localparam int N_RANDOM  = 1830;
    localparam int QUIET_AT  = N_RANDOM - 150;
    localparam int WDOG_MAX  = 60000;
    localparam int HOLD_LEN  = 300;

    typedef struct packed {
        logic [2:0] cmd;
        logic [9:0] row_a;
        logic [9:0] row_b;
        logic [9:0] row_dst;
        logic [9:0] count;
        logic [3:0] col;
        logic [7:0] wval;
    } command_t;

    class sp_scoreboard;
        logic [7:0]  mem [NROWS][NDIM];
        logic [15:0] pending_q [$];
        int          n_bad;
        int          n_checked;
        int          n_mm;
        int          n_bf;
        int          n_range;

        function void clear_mem();
            foreach (mem[r, c]) mem[r][c] = '0;
        endfunction

        function void run_mm(int a, int b, int d, int n);
            logic [7:0] acc;
            for (int i = 0; i < n; i++) begin
                for (int c = 0; c < NDIM; c++) mem[(d + i) % NROWS][c] = '0;
                for (int c = 0; c < NDIM; c++) begin
                    acc = '0;
                    for (int k = 0; k < NDIM; k++)
                        acc += mem[(a + i) % NROWS][k] * mem[(b + k) % NROWS][c];
                    mem[(d + i) % NROWS][c] = acc;
                end
            end
        endfunction

        function void run_bf(int a, int b, int d, int n);
            logic [7:0] acc;
            logic [7:0] ea;
            logic [7:0] eb;
            for (int i = 0; i < n; i++) begin
                ea = mem[(a + i) % NROWS][0];
                eb = mem[(b + i) % NROWS][0];
                for (int c = 0; c < NDIM; c++) mem[(d + i) % NROWS][c] = '0;
                mem[(d + i) % NROWS][0] = ea + eb;
                for (int c = 1; c < NDIM; c++) begin
                    acc = '0;
                    for (int k = 1; k < NDIM; k++)
                        acc += mem[(a + i) % NROWS][k] * mem[(b + i) % NROWS][k];
                    mem[(d + i) % NROWS][c] = acc;
                end
            end
        endfunction

        function void note(command_t t);
            logic [7:0] rv;
            logic [1:0] st;
            int         bend;
            rv = '0;
            st = ST_DONE;
            case (t.cmd)
                CMD_WRITE, CMD_READ: begin
                    if (t.row_a >= NROWS || t.col >= NDIM) st = ST_RANGE;
                    else if (t.cmd == CMD_WRITE) mem[t.row_a][t.col] = t.wval;
                    else rv = mem[t.row_a][t.col];
                end
                CMD_MM, CMD_BF: begin
                    if (t.count != 0) begin
                        bend = int'(t.row_b) + ((t.cmd == CMD_MM) ? NDIM : int'(t.count));
                        if (int'(t.row_a) + int'(t.count) > NROWS ||
                            int'(t.row_dst) + int'(t.count) > NROWS || bend > NROWS) begin
                            st = ST_RANGE;
                            n_range++;
                        end else if (t.cmd == CMD_MM) begin
                            run_mm(int'(t.row_a), int'(t.row_b), int'(t.row_dst),
                                   int'(t.count));
                            n_mm++;
                        end else begin
                            run_bf(int'(t.row_a), int'(t.row_b), int'(t.row_dst),
                                   int'(t.count));
                            n_bf++;
                        end
                    end
                end
                CMD_FENCE: ;
                default: st = ST_ILLEGAL;
            endcase
            pending_q.push_back({6'd0, st, rv});
        endfunction

        function void check(logic [15:0] got);
            logic [15:0] want;
            if (pending_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result transfer %h", got);
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (got[7:0] !== want[7:0] || got[9:8] !== want[9:8] || got[15:10] !== '0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch #%0d: read_value exp %h got %h, status exp %0d got %0d",
                             n_checked, want[7:0], got[7:0], want[9:8], got[9:8]);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    sp_scoreboard sb;
    bit           quiet = 1'b0;
    bit           hold_req = 1'b0;
    int           idle_cycles = 0;

    always #6 aclk = ~aclk;

    scratchpad_matrix_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog: no transfer for %0d cycles", WDOG_MAX);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stalls plus one long hold
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    task automatic send_cmd(command_t t);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, t.wval, t.col, t.count, t.row_dst, t.row_b, t.row_a, t.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note(t);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic issue(logic [2:0] cmd, int ra, int rb, int rd, int n, int c, int v);
        command_t t;
        t.cmd = cmd; t.row_a = 10'(ra); t.row_b = 10'(rb); t.row_dst = 10'(rd);
        t.count = 10'(n); t.col = 4'(c); t.wval = 8'(v);
        send_cmd(t);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    function automatic command_t random_cmd();
        command_t t;
        int       sel;
        int       top;
        t = command_t'(55'({$urandom, $urandom}));
        sel = $urandom_range(0, 99);
        top = ($urandom_range(0, 9) == 0) ? NROWS - 1 : 31;
        if (sel < 35) begin
            t.cmd = CMD_WRITE;
            t.row_a = 10'($urandom_range(0, top));
        end else if (sel < 65) begin
            t.cmd = CMD_READ;
            t.row_a = 10'($urandom_range(0, top));
        end else if (sel < 80) begin
            t.cmd = $urandom_range(0, 1) ? CMD_MM : CMD_BF;
            t.count = ($urandom_range(0, 7) == 0) ? 10'd3 : 10'($urandom_range(1, 2));
            t.row_a = 10'($urandom_range(0, 40));
            t.row_b = 10'($urandom_range(0, 30));
            t.row_dst = 10'($urandom_range(0, 40));
        end else if (sel < 84) begin
            t.cmd = $urandom_range(0, 1) ? CMD_MM : CMD_BF;
            t.count = 10'($urandom_range(200, 1023));
            t.row_dst = 10'($urandom_range(900, 1023));
        end else if (sel < 86) begin
            t.cmd = CMD_MM;
            t.count = 10'd1;
            t.row_a = 10'($urandom_range(0, 40));
            t.row_dst = 10'($urandom_range(0, 40));
            t.row_b = 10'($urandom_range(NROWS - NDIM + 1, NROWS - 1));
        end else if (sel < 90) begin
            t.cmd = $urandom_range(0, 1) ? CMD_MM : CMD_BF;
            t.count = '0;
        end else if (sel < 95) begin
            t.cmd = CMD_FENCE;
        end else begin
            t.cmd = 3'($urandom_range(5, 7));
        end
        return t;
    endfunction

    initial begin
        sb = new();
        sb.clear_mem();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // element extremes and read-back
        issue(CMD_WRITE, 0, 0, 0, 0, 0, -128);
        issue(CMD_WRITE, NROWS - 1, 0, 0, 0, NDIM - 1, 127);
        issue(CMD_READ, 0, 0, 0, 0, 0, 0);
        issue(CMD_READ, NROWS - 1, 0, 0, 0, NDIM - 1, 0);
        issue(CMD_READ, 512, 0, 0, 0, 7, 0);
        for (int i = 0; i < 6; i++)
            issue(CMD_WRITE, i % 3, 0, 0, 0, $urandom_range(0, 15), $urandom_range(0, 255));
        // overlapping operand and destination rows
        issue(CMD_MM, 0, 0, 0, 1, 0, 0);
        issue(CMD_BF, 0, 1, 1, 2, 0, 0);
        issue(CMD_READ, 1, 0, 0, 0, 0, 0);
        // largest valid run kept moderate
        issue(CMD_MM, 0, 0, 20, 16, 0, 0);
        // zero count, range errors, fence, illegal codes
        issue(CMD_MM, NROWS - 1, NROWS - 1, NROWS - 1, 0, 0, 0);
        issue(CMD_MM, 0, NROWS - NDIM + 1, 0, 1, 0, 0);
        issue(CMD_BF, NROWS - 1, 0, 0, 2, 0, 0);
        issue(CMD_BF, 0, 0, NROWS - 1, 1023, 0, 0);
        issue(CMD_FENCE, 0, 0, 0, 0, 0, 0);
        issue(3'd5, 0, 0, 0, 0, 0, 0);
        issue(3'd6, 0, 0, 0, 0, 0, 0);
        issue(3'd7, 1023, 1023, 1023, 1023, 15, 255);

        // sender pause until everything has returned
        wait_drained();
        hold_req = 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == QUIET_AT) quiet = 1'b1;
            send_cmd(random_cmd());
        end
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("%0d results checked: %0d matmul, %0d block-float, %0d range errors",
                 sb.n_checked, sb.n_mm, sb.n_bf, sb.n_range);
        $display("element access, fence and illegal codes covered, long result stall done");
        if (sb.n_bad == 0 && sb.pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", sb.n_bad);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/smeng_pkg.sv
hdl/smeng_ctrl.sv
hdl/smeng_dpath.sv
hdl/scratchpad_matrix_engine.sv
hdl/smeng_checker.sv
sim/tb_scratchpad_matrix_engine.sv
